[rtl/fast_atan2_angle_defines.svh]
// assertion macros for the fast_atan2_angle block
// used by the top level; expects i_clk and i_rst_n in the including module
`ifndef FAST_ATAN2_ANGLE_DEFINES_SVH
`define FAST_ATAN2_ANGLE_DEFINES_SVH
`ifndef SYNTHESIS
`define FATAN_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("fatan check failed");
`define FATAN_ASSERT_LAT(lbl, dly, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> ##(dly) (cons)) \
        else $error("fatan latency check failed");
`else
`define FATAN_ASSERT_IMP(lbl, ante, cons)
`define FATAN_ASSERT_LAT(lbl, dly, ante, cons)
`endif
`endif

[rtl/fatan_pkg.sv]
// shared widths, constants, types and helpers of the fast_atan2_angle block
// no dependencies
package fatan_pkg;

    localparam int GRAD_WIDTH  = 16;
    localparam int MAG_WIDTH   = GRAD_WIDTH;
    localparam int FRAC_BITS   = 16;
    localparam int C_WIDTH     = FRAC_BITS + 1;
    localparam int DIV_STAGES  = C_WIDTH;
    localparam int POLY_STAGES = 9;
    localparam int OUT_STAGES  = 6;
    localparam int LATENCY     = 1 + DIV_STAGES + POLY_STAGES + OUT_STAGES;

    localparam int T_WIDTH     = 32;
    localparam int PROD_W      = T_WIDTH + C_WIDTH + 1;
    localparam int B_WIDTH     = 35;
    localparam int ANG_WIDTH   = 33;
    localparam int ANGLE_W     = 16;
    localparam int RES_W       = 17;
    localparam int DEG_K_W     = 22;
    localparam int LO_W        = 17;
    localparam int HI_W        = ANG_WIDTH - LO_W;
    localparam int PL_W        = LO_W + DEG_K_W;
    localparam int PH_W        = HI_W + DEG_K_W;
    localparam int SUM_W       = 56;
    localparam int RAD_SHIFT   = 17;
    localparam int DEG_SHIFT   = 39;

    localparam logic signed [T_WIDTH-1:0] P1 = 32'sd1073514020;
    localparam logic signed [T_WIDTH-1:0] P3 = -32'sd349834103;
    localparam logic signed [T_WIDTH-1:0] P5 = 32'sd167051305;
    localparam logic signed [T_WIDTH-1:0] P7 = -32'sd47595277;

    localparam logic signed [B_WIDTH-1:0] HALF_PI = 35'sd1686629713;
    localparam logic signed [B_WIDTH-1:0] PI      = 35'sd3373259426;
    localparam logic signed [B_WIDTH-1:0] TWO_PI  = 35'sd6746518852;

    localparam logic [DEG_K_W-1:0]  DEG_PER_RAD = 22'd3754936;
    localparam logic [ANG_WIDTH:0]  RAD_RND     = 34'd65536;
    localparam logic [SUM_W-1:0]    DEG_RND     = 56'd274877906944;
    localparam logic [RES_W-1:0]    DEG_FULL    = 17'd46080;
    localparam logic [RES_W-1:0]    RAD_FULL    = 17'd51472;

    typedef struct packed {
        logic zero;
        logic steep;
        logic neg_x;
        logic neg_y;
    } t_flags;

    // q16 product scaled back, rounding toward zero
    function automatic logic signed [T_WIDTH-1:0] trunc_q16(input logic signed [PROD_W-1:0] p);
        logic signed [PROD_W-1:0] adj;
        adj = p + (p[PROD_W-1] ? PROD_W'(65535) : PROD_W'(0));
        return adj[T_WIDTH+FRAC_BITS-1:FRAC_BITS];
    endfunction

endpackage

[rtl/fatan_div.sv]
// pipelined restoring divider, one quotient bit per stage: lo * 2^16 / hi
// depends on fatan_pkg
module fatan_div (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_vld,
    input  fatan_pkg::t_flags                  i_flags,
    input  logic [fatan_pkg::MAG_WIDTH-1:0]    i_lo,
    input  logic [fatan_pkg::MAG_WIDTH-1:0]    i_hi,
    output logic                               o_vld,
    output fatan_pkg::t_flags                  o_flags,
    output logic [fatan_pkg::C_WIDTH-1:0]      o_quo
);

    logic                              r_vld   [fatan_pkg::DIV_STAGES];
    fatan_pkg::t_flags                 r_flags [fatan_pkg::DIV_STAGES];
    logic [fatan_pkg::MAG_WIDTH-1:0]   r_rem   [fatan_pkg::DIV_STAGES];
    logic [fatan_pkg::MAG_WIDTH-1:0]   r_hi    [fatan_pkg::DIV_STAGES];
    logic [fatan_pkg::C_WIDTH-1:0]     r_quo   [fatan_pkg::DIV_STAGES];

    logic [fatan_pkg::MAG_WIDTH-1:0]   n_rem   [fatan_pkg::DIV_STAGES];
    logic [fatan_pkg::C_WIDTH-1:0]     n_quo   [fatan_pkg::DIV_STAGES];
    logic [fatan_pkg::MAG_WIDTH:0]     trial   [fatan_pkg::DIV_STAGES];
    logic [fatan_pkg::MAG_WIDTH:0]     diff    [fatan_pkg::DIV_STAGES];
    logic [fatan_pkg::MAG_WIDTH-1:0]   div_in  [fatan_pkg::DIV_STAGES];
    logic [fatan_pkg::C_WIDTH-1:0]     quo_in  [fatan_pkg::DIV_STAGES];

    always_comb begin
        for (int s = 0; s < fatan_pkg::DIV_STAGES; s++) begin
            if (s == 0) begin
                // first step has lo <= hi, so no shift
                trial[s]  = {1'b0, i_lo};
                div_in[s] = i_hi;
                quo_in[s] = '0;
            end else begin
                trial[s]  = {r_rem[s-1], 1'b0};
                div_in[s] = r_hi[s-1];
                quo_in[s] = r_quo[s-1];
            end
            diff[s] = trial[s] - {1'b0, div_in[s]};
            if (!diff[s][fatan_pkg::MAG_WIDTH]) begin
                n_rem[s] = diff[s][fatan_pkg::MAG_WIDTH-1:0];
            end else begin
                n_rem[s] = trial[s][fatan_pkg::MAG_WIDTH-1:0];
            end
            n_quo[s] = {quo_in[s][fatan_pkg::C_WIDTH-2:0], !diff[s][fatan_pkg::MAG_WIDTH]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < fatan_pkg::DIV_STAGES; s++) begin
                r_vld[s] <= 1'b0;
            end
        end else begin
            r_vld[0] <= i_vld;
            for (int s = 1; s < fatan_pkg::DIV_STAGES; s++) begin
                r_vld[s] <= r_vld[s-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_flags[0] <= i_flags;
        r_hi[0]    <= i_hi;
        for (int s = 1; s < fatan_pkg::DIV_STAGES; s++) begin
            r_flags[s] <= r_flags[s-1];
            r_hi[s]    <= r_hi[s-1];
        end
        for (int s = 0; s < fatan_pkg::DIV_STAGES; s++) begin
            r_rem[s] <= n_rem[s];
            r_quo[s] <= n_quo[s];
        end
    end

    assign o_vld   = r_vld[fatan_pkg::DIV_STAGES-1];
    assign o_flags = r_flags[fatan_pkg::DIV_STAGES-1];
    assign o_quo   = r_quo[fatan_pkg::DIV_STAGES-1];

endmodule

[rtl/fatan_poly.sv]
// odd 7th-order atan polynomial in the q16 ratio, horner form, at most one multiply per stage
// depends on fatan_pkg
module fatan_poly (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_vld,
    input  fatan_pkg::t_flags                      i_flags,
    input  logic [fatan_pkg::C_WIDTH-1:0]          i_c,
    output logic                                   o_vld,
    output fatan_pkg::t_flags                      o_flags,
    output logic signed [fatan_pkg::T_WIDTH-1:0]   o_base
);

    logic              r_vld   [fatan_pkg::POLY_STAGES];
    fatan_pkg::t_flags r_flags [fatan_pkg::POLY_STAGES];

    logic [fatan_pkg::C_WIDTH-1:0]          r1_c, r2_c, r3_c, r4_c, r5_c, r6_c, r7_c;
    logic [fatan_pkg::C_WIDTH-1:0]          r1_c2, r2_c2, r3_c2, r4_c2, r5_c2;
    logic signed [fatan_pkg::PROD_W-1:0]    r2_prod, r4_prod, r6_prod, r8_prod;
    logic signed [fatan_pkg::T_WIDTH-1:0]   r3_t, r5_t, r7_t, r9_b;

    logic [2*fatan_pkg::C_WIDTH-1:0]        n1_sq;
    logic signed [fatan_pkg::PROD_W-1:0]    n2_prod, n4_prod, n6_prod, n8_prod;

    always_comb begin
        n1_sq   = (2*fatan_pkg::C_WIDTH)'(i_c) * (2*fatan_pkg::C_WIDTH)'(i_c);
        n2_prod = fatan_pkg::P7 * $signed({1'b0, r1_c2});
        n4_prod = r3_t * $signed({1'b0, r3_c2});
        n6_prod = r5_t * $signed({1'b0, r5_c2});
        n8_prod = r7_t * $signed({1'b0, r7_c});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < fatan_pkg::POLY_STAGES; s++) begin
                r_vld[s] <= 1'b0;
            end
        end else begin
            r_vld[0] <= i_vld;
            for (int s = 1; s < fatan_pkg::POLY_STAGES; s++) begin
                r_vld[s] <= r_vld[s-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_flags[0] <= i_flags;
        for (int s = 1; s < fatan_pkg::POLY_STAGES; s++) begin
            r_flags[s] <= r_flags[s-1];
        end
        r1_c    <= i_c;
        r1_c2   <= n1_sq[fatan_pkg::FRAC_BITS+fatan_pkg::C_WIDTH-1:fatan_pkg::FRAC_BITS];
        r2_c    <= r1_c;
        r2_c2   <= r1_c2;
        r2_prod <= n2_prod;
        r3_c    <= r2_c;
        r3_c2   <= r2_c2;
        r3_t    <= fatan_pkg::trunc_q16(r2_prod) + fatan_pkg::P5;
        r4_c    <= r3_c;
        r4_c2   <= r3_c2;
        r4_prod <= n4_prod;
        r5_c    <= r4_c;
        r5_c2   <= r4_c2;
        r5_t    <= fatan_pkg::trunc_q16(r4_prod) + fatan_pkg::P3;
        r6_c    <= r5_c;
        r6_prod <= n6_prod;
        r7_c    <= r6_c;
        r7_t    <= fatan_pkg::trunc_q16(r6_prod) + fatan_pkg::P1;
        r8_prod <= n8_prod;
        r9_b    <= fatan_pkg::trunc_q16(r8_prod);
    end

    assign o_vld   = r_vld[fatan_pkg::POLY_STAGES-1];
    assign o_flags = r_flags[fatan_pkg::POLY_STAGES-1];
    assign o_base  = r9_b;

endmodule

[rtl/fatan_out.sv]
// octant fold of the base angle and conversion to degrees or radians
// depends on fatan_pkg
module fatan_out (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_vld,
    input  fatan_pkg::t_flags                      i_flags,
    input  logic signed [fatan_pkg::T_WIDTH-1:0]   i_base,
    input  logic                                   i_unit,
    output logic                                   o_vld,
    output logic                                   o_unit,
    output logic [fatan_pkg::ANGLE_W-1:0]          o_angle
);

    logic              r_vld   [fatan_pkg::OUT_STAGES];
    fatan_pkg::t_flags r_flags [fatan_pkg::OUT_STAGES];

    logic signed [fatan_pkg::B_WIDTH-1:0]  r1_b, r2_b;
    logic [fatan_pkg::ANG_WIDTH-1:0]       r3_ang;
    logic [fatan_pkg::RES_W-1:0]           r4_rad, r5_rad, r5_deg;
    logic [fatan_pkg::PL_W-1:0]            r4_pl;
    logic [fatan_pkg::PH_W-1:0]            r4_ph;
    logic [fatan_pkg::ANGLE_W-1:0]         r_angle;
    logic                                  r_unit;

    logic signed [fatan_pkg::B_WIDTH-1:0]  base_ext;
    logic signed [fatan_pkg::B_WIDTH-1:0]  n1_b, n2_b, n3_b;
    logic [fatan_pkg::ANG_WIDTH-1:0]       n3_ang;
    logic [fatan_pkg::ANG_WIDTH:0]         n4_rsum;
    logic [fatan_pkg::PL_W-1:0]            n4_pl;
    logic [fatan_pkg::PH_W-1:0]            n4_ph;
    logic [fatan_pkg::SUM_W-1:0]           n5_sum;
    logic [fatan_pkg::RES_W-1:0]           n6_res;

    always_comb begin
        base_ext = $signed({{(fatan_pkg::B_WIDTH-fatan_pkg::T_WIDTH){i_base[fatan_pkg::T_WIDTH-1]}},
                            i_base});
        n1_b = i_flags.steep ? fatan_pkg::HALF_PI - base_ext : base_ext;
        n2_b = r_flags[0].neg_x ? fatan_pkg::PI - r1_b : r1_b;
        n3_b = r_flags[1].neg_y ? fatan_pkg::TWO_PI - r2_b : r2_b;
        n3_ang = n3_b[fatan_pkg::B_WIDTH-1] ? '0 : n3_b[fatan_pkg::ANG_WIDTH-1:0];

        n4_rsum = {1'b0, r3_ang} + fatan_pkg::RAD_RND;
        n4_pl   = fatan_pkg::PL_W'(r3_ang[fatan_pkg::LO_W-1:0])
                  * fatan_pkg::PL_W'(fatan_pkg::DEG_PER_RAD);
        n4_ph   = fatan_pkg::PH_W'(r3_ang[fatan_pkg::ANG_WIDTH-1:fatan_pkg::LO_W])
                  * fatan_pkg::PH_W'(fatan_pkg::DEG_PER_RAD);

        n5_sum = (fatan_pkg::SUM_W'(r4_ph) << fatan_pkg::LO_W) + fatan_pkg::SUM_W'(r4_pl)
                 + fatan_pkg::DEG_RND;

        // full turn after rounding wraps to zero
        if (r_flags[4].zero) begin
            n6_res = '0;
        end else if (i_unit) begin
            n6_res = (r5_rad >= fatan_pkg::RAD_FULL) ? '0 : r5_rad;
        end else begin
            n6_res = (r5_deg >= fatan_pkg::DEG_FULL) ? '0 : r5_deg;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < fatan_pkg::OUT_STAGES; s++) begin
                r_vld[s] <= 1'b0;
            end
        end else begin
            r_vld[0] <= i_vld;
            for (int s = 1; s < fatan_pkg::OUT_STAGES; s++) begin
                r_vld[s] <= r_vld[s-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_flags[0] <= i_flags;
        for (int s = 1; s < fatan_pkg::OUT_STAGES; s++) begin
            r_flags[s] <= r_flags[s-1];
        end
        r1_b    <= n1_b;
        r2_b    <= n2_b;
        r3_ang  <= n3_ang;
        r4_rad  <= n4_rsum[fatan_pkg::ANG_WIDTH:fatan_pkg::RAD_SHIFT];
        r4_pl   <= n4_pl;
        r4_ph   <= n4_ph;
        r5_rad  <= r4_rad;
        r5_deg  <= n5_sum[fatan_pkg::SUM_W-1:fatan_pkg::DEG_SHIFT];
        r_angle <= n6_res[fatan_pkg::ANGLE_W-1:0];
        r_unit  <= i_unit;
    end

    assign o_vld   = r_vld[fatan_pkg::OUT_STAGES-1];
    assign o_unit  = r_unit;
    assign o_angle = r_angle;

endmodule

[rtl/fast_atan2_angle.sv]
// top level of the fast_atan2_angle block: magnitude stage, divider, polynomial, fold
// depends on fatan_pkg, fatan_div, fatan_poly, fatan_out and fast_atan2_angle_defines.svh
//
// One gradient pair is taken on every clock cycle with start high and busy low; busy is high
// only while reset is applied and for the cycle after it. Each angle passes the input register,
// divider, polynomial and fold stages and is strobed on o_done for one cycle; the receiver cannot
// stall, so the result must be taken then. The input register feeds the 17-stage divider (one
// quotient bit per stage), nine polynomial multiply/add stages, six octant fold and unit scaling stages.
// The angle unit is sampled at the last stage, so change it only while no transfer is in flight.
`include "fast_atan2_angle_defines.svh"
module fast_atan2_angle (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   start,
    output logic                                   busy,
    input  logic                                   i_cfg_we,
    input  logic                                   i_cfg_wdata,
    input  logic [fatan_pkg::GRAD_WIDTH-1:0]       i_grad_y,
    input  logic [fatan_pkg::GRAD_WIDTH-1:0]       i_grad_x,
    output logic                                   o_done,
    output logic [fatan_pkg::ANGLE_W-1:0]          o_angle
);

    logic                              r_unit;
    logic                              r_busy;
    logic                              r_vld;
    fatan_pkg::t_flags                 r_flags;
    logic [fatan_pkg::MAG_WIDTH-1:0]   r_lo, r_hi;

    logic                              accept;
    logic [fatan_pkg::MAG_WIDTH-1:0]   mag_y, mag_x;
    fatan_pkg::t_flags                 n_flags;
    logic [fatan_pkg::MAG_WIDTH-1:0]   n_lo, n_hi;

    logic                              div_vld, poly_vld, out_unit;
    fatan_pkg::t_flags                 div_flags, poly_flags;
    logic [fatan_pkg::C_WIDTH-1:0]     div_quo;
    logic signed [fatan_pkg::T_WIDTH-1:0] poly_base;

    assign busy   = r_busy | !i_rst_n;
    assign accept = start & !busy;

    always_comb begin
        mag_y = i_grad_y[fatan_pkg::GRAD_WIDTH-1] ? (~i_grad_y + 1'b1) : i_grad_y;
        mag_x = i_grad_x[fatan_pkg::GRAD_WIDTH-1] ? (~i_grad_x + 1'b1) : i_grad_x;
        n_flags.zero  = (mag_y == '0) && (mag_x == '0);
        n_flags.steep = mag_y > mag_x;
        n_flags.neg_x = i_grad_x[fatan_pkg::GRAD_WIDTH-1];
        n_flags.neg_y = i_grad_y[fatan_pkg::GRAD_WIDTH-1];
        n_lo = n_flags.steep ? mag_x : mag_y;
        n_hi = n_flags.steep ? mag_y : mag_x;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_unit <= 1'b0;
            r_busy <= 1'b1;
            r_vld  <= 1'b0;
        end else begin
            r_busy <= 1'b0;
            r_vld  <= accept;
            if (i_cfg_we) begin
                r_unit <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_flags <= n_flags;
        r_lo    <= n_lo;
        r_hi    <= n_hi;
    end

    fatan_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_vld),
        .i_flags (r_flags),
        .i_lo    (r_lo),
        .i_hi    (r_hi),
        .o_vld   (div_vld),
        .o_flags (div_flags),
        .o_quo   (div_quo)
    );

    fatan_poly u_poly (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (div_vld),
        .i_flags (div_flags),
        .i_c     (div_quo),
        .o_vld   (poly_vld),
        .o_flags (poly_flags),
        .o_base  (poly_base)
    );

    fatan_out u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (poly_vld),
        .i_flags (poly_flags),
        .i_base  (poly_base),
        .i_unit  (r_unit),
        .o_vld   (o_done),
        .o_unit  (out_unit),
        .o_angle (o_angle)
    );

    `FATAN_ASSERT_LAT(a_latency, fatan_pkg::LATENCY, accept, o_done)
    `FATAN_ASSERT_IMP(a_in_turn, o_done, (out_unit && (17'(o_angle) < fatan_pkg::RAD_FULL)) || (!out_unit && (17'(o_angle) < fatan_pkg::DEG_FULL)))
    `FATAN_ASSERT_LAT(a_zero_in, fatan_pkg::LATENCY, accept && (i_grad_y == '0) && (i_grad_x == '0), o_angle == '0)

endmodule

[tb/sv/tb_top.sv]
// self-checking bench for fast_atan2_angle: drives gradient pairs and checks every angle
// against a bit-exact fixed-point predictor in both angle units; needs fatan_pkg and the rtl
module tb_top;

    localparam int GRAD_WIDTH = fatan_pkg::GRAD_WIDTH;
    localparam int ANGLE_W    = fatan_pkg::ANGLE_W;

    localparam logic UNIT_DEG = 1'b0;
    localparam logic UNIT_RAD = 1'b1;

    localparam longint Q30_P1       = 64'sd1073514020;
    localparam longint Q30_P3       = -64'sd349834103;
    localparam longint Q30_P5       = 64'sd167051305;
    localparam longint Q30_P7       = -64'sd47595277;
    localparam longint Q30_HALF_PI  = 64'sd1686629713;
    localparam longint Q30_PI       = 64'sd3373259426;
    localparam longint Q30_TWO_PI   = 64'sd6746518852;
    localparam longint unsigned DEG_SCALE = 64'd3754936;
    localparam longint unsigned DEG_WRAP  = 64'd46080;
    localparam longint unsigned RAD_WRAP  = 64'd51472;

    typedef struct {
        logic [GRAD_WIDTH-1:0] gy;
        logic [GRAD_WIDTH-1:0] gx;
    } t_grad_pair;

    typedef struct {
        logic [GRAD_WIDTH-1:0] gy;
        logic [GRAD_WIDTH-1:0] gx;
        logic                  unit;
        logic [ANGLE_W-1:0]    angle;
    } t_angle_exp;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  start       = 1'b0;
    logic                  busy;
    logic                  i_cfg_we    = 1'b0;
    logic                  i_cfg_wdata = 1'b0;
    logic [GRAD_WIDTH-1:0] i_grad_y    = '0;
    logic [GRAD_WIDTH-1:0] i_grad_x    = '0;
    logic                  o_done;
    logic [ANGLE_W-1:0]    o_angle;

    t_grad_pair  pending_pairs[$];
    t_angle_exp  expected_angles[$];
    logic        unit_setting    = UNIT_DEG;
    int          sender_idle_pct = 0;
    int          gap_left        = 0;
    int          failures        = 0;

    int corner_pairs [0:43] = '{
        0, 0,           32767, 0,       -32768, 0,      0, 32767,
        0, -32768,      -32768, -32768, 32767, 32767,   1, 1,
        -1, -1,         1, -1,          -1, 1,          32767, -32768,
        -32768, 32767,  1, 32767,       32767, 1,       -1, -32768,
        -32768, -1,     -1, 32767,      -32768, 1,      5, -3,
        -32767, 32767,  32767, -32767
    };

    fast_atan2_angle dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_grad_y    (i_grad_y),
        .i_grad_x    (i_grad_x),
        .o_done      (o_done),
        .o_angle     (o_angle)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [ANGLE_W-1:0] expected_angle(input logic [GRAD_WIDTH-1:0] gy,
                                                          input logic [GRAD_WIDTH-1:0] gx,
                                                          input logic unit);
        longint ay, ax, lo, hi, c, c2, t, b;
        longint unsigned r;
        logic steep;
        ay = gy[GRAD_WIDTH-1] ? (longint'(1) << GRAD_WIDTH) - longint'({48'd0, gy})
                              : longint'({48'd0, gy});
        ax = gx[GRAD_WIDTH-1] ? (longint'(1) << GRAD_WIDTH) - longint'({48'd0, gx})
                              : longint'({48'd0, gx});
        if (ay == 0 && ax == 0)
            return '0;
        steep = ay > ax;
        lo = steep ? ax : ay;
        hi = steep ? ay : ax;
        c  = (lo << 16) / hi;
        c2 = (c * c) >>> 16;
        // horner in q30, each step truncating toward zero
        t = Q30_P7;
        t = (t * c2) / 65536 + Q30_P5;
        t = (t * c2) / 65536 + Q30_P3;
        t = (t * c2) / 65536 + Q30_P1;
        b = (t * c) / 65536;
        if (steep)
            b = Q30_HALF_PI - b;
        if (gx[GRAD_WIDTH-1])
            b = Q30_PI - b;
        if (gy[GRAD_WIDTH-1])
            b = Q30_TWO_PI - b;
        if (b < 0)
            b = 0;
        if (unit == UNIT_RAD) begin
            r = (longint'(b) + 64'd65536) >> 17;
            if (r >= RAD_WRAP)
                r = 0;
        end else begin
            r = (longint'(b) * DEG_SCALE + (64'd1 << 38)) >> 39;
            if (r >= DEG_WRAP)
                r = 0;
        end
        return r[ANGLE_W-1:0];
    endfunction

    function automatic t_grad_pair random_grad_pair();
        t_grad_pair p;
        int kind, m, n;
        kind = $urandom_range(0, 9);
        if (kind <= 3) begin
            p.gy = GRAD_WIDTH'($urandom);
            p.gx = GRAD_WIDTH'($urandom);
        end else if (kind <= 5) begin
            p.gy = GRAD_WIDTH'($urandom_range(0, 16) - 8);
            p.gx = GRAD_WIDTH'($urandom_range(0, 16) - 8);
        end else if (kind == 6) begin
            p.gy = GRAD_WIDTH'(corner_pairs[$urandom_range(0, 43)]);
            p.gx = GRAD_WIDTH'(corner_pairs[$urandom_range(0, 43)]);
        end else if (kind <= 8) begin
            // near the diagonal, where the steep decision flips
            m = $urandom_range(2, 32765);
            n = m + $urandom_range(0, 4) - 2;
            p.gy = $urandom_range(0, 1) ? GRAD_WIDTH'(-m) : GRAD_WIDTH'(m);
            p.gx = $urandom_range(0, 1) ? GRAD_WIDTH'(-n) : GRAD_WIDTH'(n);
        end else begin
            p.gy = GRAD_WIDTH'($urandom);
            p.gx = '0;
            if ($urandom_range(0, 1)) begin
                p.gx = p.gy;
                p.gy = '0;
            end
        end
        return p;
    endfunction

    // driver
    always @(posedge i_clk) begin
        t_grad_pair p;
        t_angle_exp e;
        if (!i_rst_n) begin
            start <= 1'b0;
            gap_left = 0;
        end else begin
            if (start && !busy) begin
                e.gy    = i_grad_y;
                e.gx    = i_grad_x;
                e.unit  = unit_setting;
                e.angle = expected_angle(i_grad_y, i_grad_x, unit_setting);
                expected_angles.push_back(e);
            end
            if (!(start && busy)) begin
                if (gap_left > 0) begin
                    gap_left = gap_left - 1;
                    start <= 1'b0;
                end else if (pending_pairs.size() == 0) begin
                    start <= 1'b0;
                end else if (sender_idle_pct > 0 && $urandom_range(0, 99) < sender_idle_pct) begin
                    gap_left = $urandom_range(0, 4);
                    start <= 1'b0;
                end else begin
                    p = pending_pairs.pop_front();
                    i_grad_y <= p.gy;
                    i_grad_x <= p.gx;
                    start    <= 1'b1;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_angle_exp e;
        if (i_rst_n && o_done) begin
            if (expected_angles.size() == 0) begin
                $display("%0t unexpected angle transfer: expected none, actual %0d",
                         $time, o_angle);
                failures = failures + 1;
            end else begin
                e = expected_angles.pop_front();
                if (o_angle !== e.angle) begin
                    $display("%0t angle mismatch (y=%0d x=%0d unit=%0d): expected %0d actual %0d",
                             $time, $signed(e.gy), $signed(e.gx), e.unit, e.angle, o_angle);
                    failures = failures + 1;
                end
            end
        end
    end

    task automatic wait_idle();
        while (pending_pairs.size() != 0 || start || expected_angles.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic set_angle_unit(input logic unit);
        @(posedge i_clk);
        i_cfg_we     <= 1'b1;
        i_cfg_wdata  <= unit;
        unit_setting  = unit;
        @(posedge i_clk);
        i_cfg_we     <= 1'b0;
    endtask

    task automatic run_phase(input logic unit, input int idle_pct, input int count,
                             input bit corners);
        t_grad_pair p;
        wait_idle();
        set_angle_unit(unit);
        sender_idle_pct = idle_pct;
        if (corners) begin
            for (int i = 0; i < 22; i++) begin
                p.gy = GRAD_WIDTH'(corner_pairs[2*i]);
                p.gx = GRAD_WIDTH'(corner_pairs[2*i+1]);
                pending_pairs.push_back(p);
            end
        end
        for (int i = 0; i < count; i++)
            pending_pairs.push_back(random_grad_pair());
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        while (busy)
            @(posedge i_clk);
        run_phase(UNIT_DEG, 25, 0,   1'b1);
        run_phase(UNIT_RAD, 25, 0,   1'b1);
        run_phase(UNIT_DEG, 30, 200, 1'b0);
        run_phase(UNIT_RAD, 0,  200, 1'b0);
        run_phase(UNIT_DEG, 60, 200, 1'b0);
        run_phase(UNIT_RAD, 15, 200, 1'b0);
        run_phase(UNIT_DEG, 40, 200, 1'b0);
        run_phase(UNIT_RAD, 0,  200, 1'b0);
        wait_idle();
        repeat (fatan_pkg::LATENCY + 8) @(posedge i_clk);
        if (failures == 0 && expected_angles.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("TB_ERROR");
        $finish;
    end

endmodule

[sim.f]
+incdir+rtl
rtl/fatan_pkg.sv
rtl/fatan_div.sv
rtl/fatan_poly.sv
rtl/fatan_out.sv
rtl/fast_atan2_angle.sv
tb/sv/tb_top.sv
